/* hw/rtl/tvgd_pkg.sv */
// ----------------------------------------------------------------------------
// tvgd_pkg
// Shared types, register indexes and constants for the TV gradient pass core.
// ----------------------------------------------------------------------------
package tvgd_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int HeightLimit = 4096;
  localparam int RowW        = 12;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_REG_WEIGHT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EPS_SQUARED  = 3'd4;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd1024;
  localparam logic [31:0] REG_WEIGHT_RST   = 32'd42950;
  localparam logic [17:0] STEP_SIZE_RST    = 18'd122076;
  localparam logic [31:0] EPS_SQUARED_RST  = 32'd68719;

  typedef struct packed {
    logic signed [19:0] est_here;
    logic signed [19:0] est_right;
    logic signed [19:0] est_below;
    logic signed [19:0] conv_term;
    logic signed [19:0] data_term;
    logic               final_pass;
  } in_word_t;

  typedef struct packed {
    logic signed [19:0] new_estimate;
    logic [7:0]         out_pixel;
    logic               end_of_frame;
  } out_word_t;

  // pixel word plus its position class, as the front hands it to the back
  typedef struct packed {
    in_word_t word;
    logic     last_col;
    logic     last_row;
    logic     use_div;
    logic     end_of_frame;
  } task_t;

  typedef struct packed {
    logic [31:0] reg_weight;
    logic [17:0] step_size;
    logic [31:0] eps_squared;
  } coef_t;

endpackage

/* hw/rtl/tvgd_stream_if.sv */
// ----------------------------------------------------------------------------
// tvgd_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface tvgd_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tvgd_front.sv */
// ----------------------------------------------------------------------------
// tvgd_front
// Accepts pixel words, tracks raster position and tags edge conditions.
// ----------------------------------------------------------------------------
module tvgd_front #(
  parameter int MaxWidth = tvgd_pkg::MaxWidthDef,
  parameter int ColW     = $clog2(MaxWidth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tvgd_stream_if.sink        in_chan_i,
  input  logic [10:0]        image_width_i,
  input  logic [12:0]        image_height_i,
  output tvgd_pkg::task_t    task_o,
  output logic [ColW-1:0]    col_o,
  output logic               push_o,
  input  logic               full_i
);
  import tvgd_pkg::*;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [31:0]     w_lim, h_lim;
  logic            last_col, last_row;

  always_comb begin
    w_lim = 32'(image_width_i);
    if (w_lim < 32'd2) w_lim = 32'd2;
    if (w_lim > 32'(MaxWidth)) w_lim = 32'(MaxWidth);
    h_lim = 32'(image_height_i);
    if (h_lim < 32'd2) h_lim = 32'd2;
    if (h_lim > 32'(HeightLimit)) h_lim = 32'(HeightLimit);
  end

  assign last_col = 32'(col_q) >= (w_lim - 32'd1);
  assign last_row = 32'(row_q) >= (h_lim - 32'd1);

  assign in_chan_i.ready = !full_i;
  assign push_o          = in_chan_i.valid && !full_i;

  always_comb begin
    task_o.word         = in_chan_i.data;
    task_o.last_col     = last_col;
    task_o.last_row     = last_row;
    task_o.use_div      = (col_q != '0) && (row_q != '0);
    task_o.end_of_frame = last_col && last_row;
    col_o               = col_q;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* hw/rtl/tvgd_queue.sv */
// ----------------------------------------------------------------------------
// tvgd_queue
// Small register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module tvgd_queue #(
  parameter int DataW = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             avail_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(Depth);
  assign avail_o = cnt_q != '0;
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

endmodule

/* hw/rtl/tvgd_back.sv */
// ----------------------------------------------------------------------------
// tvgd_back
// Sequenced arithmetic for one pixel: squares, sqrt, normalize, update.
// ----------------------------------------------------------------------------
module tvgd_back #(
  parameter int MaxWidth = tvgd_pkg::MaxWidthDef,
  parameter int ColW     = $clog2(MaxWidth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tvgd_pkg::task_t task_i,
  input  logic [ColW-1:0] col_i,
  input  logic            avail_i,
  output logic            pop_o,
  input  tvgd_pkg::coef_t coef_i,
  tvgd_stream_if.source   out_chan_o
);
  import tvgd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQX   = 4'd1;
  localparam logic [3:0] ST_SQY   = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_DINIT = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_LAM   = 4'd7;
  localparam logic [3:0] ST_ERR   = 4'd8;
  localparam logic [3:0] ST_UPD   = 4'd9;

  logic [3:0]         st_q, st_d;
  task_t              task_q;
  logic [ColW-1:0]    col_q;
  logic signed [20:0] gx_q, gy_q;
  logic [42:0]        acc_q;
  logic [63:0]        v_q, r_q;
  logic [4:0]         idx_q;
  logic [31:0]        rx_q, ry_q;
  logic [16:0]        qx_q, qy_q;
  logic               satx_q, saty_q;
  logic signed [17:0] dx_q, dy_q, above_q, left_q;
  logic signed [55:0] prod_q;
  logic signed [32:0] mul_a;
  logic signed [22:0] mul_b;
  logic               out_valid_q;
  out_word_t          out_q;

  logic signed [17:0] line_mem [MaxWidth];

  // sqrt step
  logic [63:0] sq_bit, sq_try;
  assign sq_bit = 64'd1 << {idx_q, 1'b0};
  assign sq_try = r_q + sq_bit;

  // magnitudes for the divider
  logic [19:0] mx, my;
  logic [30:0] qroot;
  assign mx    = 20'(gx_q[20] ? -gx_q : gx_q);
  assign my    = 20'(gy_q[20] ? -gy_q : gy_q);
  assign qroot = r_q[30:0];

  logic [31:0] rx_sh, ry_sh;
  assign rx_sh = {rx_q[30:0], 1'b0};
  assign ry_sh = {ry_q[30:0], 1'b0};

  // final normalized values
  function automatic logic signed [17:0] norm_out(input logic neg, input logic zero,
                                                  input logic sat, input logic [16:0] q);
    logic signed [17:0] res;
    begin
      if (zero) res = '0;
      else if (sat) res = neg ? -18'sd131072 : 18'sd131071;
      else res = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      norm_out = res;
    end
  endfunction

  // divergence and rounding
  logic signed [20:0] div_v;
  logic [55:0]        pm, lam_m, tau_m;
  logic signed [22:0] lam_rnd, e_v;
  logic signed [24:0] t_v, nv_w;
  logic signed [19:0] nv;
  logic [18:0]        nvp;
  logic [27:0]        p255;
  logic [12:0]        pix_w;
  logic [7:0]         pix;

  always_comb begin
    div_v = '0;
    if (task_q.use_div)
      div_v = -((21'(dy_q) - 21'(above_q)) + (21'(dx_q) - 21'(left_q)));
    pm      = prod_q[55] ? 56'(-prod_q) : 56'(prod_q);
    lam_m   = (pm + (56'd1 << 31)) >> 32;
    tau_m   = (pm + (56'd1 << 15)) >> 16;
    lam_rnd = prod_q[55] ? -$signed(23'(lam_m)) : $signed(23'(lam_m));
    e_v     = 23'(task_q.word.conv_term) - 23'(task_q.word.data_term) + lam_rnd;
    t_v     = prod_q[55] ? -$signed(25'(tau_m)) : $signed(25'(tau_m));
    nv_w    = 25'(task_q.word.est_here) - t_v;
    if (nv_w > 25'sd524287) nv = 20'sd524287;
    else if (nv_w < -25'sd524288) nv = -20'sd524288;
    else nv = nv_w[19:0];
    nvp   = nv[18:0];
    p255  = ({9'd0, nvp} << 8) - {9'd0, nvp};
    pix_w = 13'((p255 + 28'd32768) >> 16);
    pix   = '0;
    if (task_q.word.final_pass && nv > 20'sd0)
      pix = (pix_w > 13'd255) ? 8'd255 : pix_w[7:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_SQX: begin
        mul_a = 33'(gx_q);
        mul_b = 23'(gx_q);
      end
      ST_SQY: begin
        mul_a = 33'(gy_q);
        mul_b = 23'(gy_q);
      end
      ST_LAM: begin
        mul_a = $signed({1'b0, coef_i.reg_weight});
        mul_b = 23'(div_v);
      end
      ST_ERR: begin
        mul_a = $signed({15'd0, coef_i.step_size});
        mul_b = e_v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_q || out_chan_o.ready;
  assign pop_o    = (st_q == ST_IDLE) && avail_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (avail_i) st_d = ST_SQX;
      ST_SQX:   st_d = ST_SQY;
      ST_SQY:   st_d = ST_SUM;
      ST_SUM:   st_d = ST_SQRT;
      ST_SQRT:  if (idx_q == '0) st_d = ST_DINIT;
      ST_DINIT: st_d = ST_DIV;
      ST_DIV:   if (idx_q == '0) st_d = ST_LAM;
      ST_LAM:   st_d = ST_ERR;
      ST_ERR:   st_d = ST_UPD;
      ST_UPD:   if (out_free) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_LAM) left_q <= dx_q;
      if (st_q == ST_UPD && out_free) out_valid_q <= 1'b1;
      else if (out_chan_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    // tau product must hold while the update waits on the output
    if (st_q != ST_UPD) prod_q <= mul_a * mul_b;
    case (st_q)
      ST_IDLE: begin
        if (avail_i) begin
          task_q <= task_i;
          col_q  <= col_i;
          gx_q   <= task_i.last_col ? '0
                    : 21'(task_i.word.est_right) - 21'(task_i.word.est_here);
          gy_q   <= task_i.last_row ? '0
                    : 21'(task_i.word.est_below) - 21'(task_i.word.est_here);
        end
      end
      ST_SQY: acc_q <= 43'(coef_i.eps_squared) + 43'(prod_q);
      ST_SUM: begin
        v_q   <= 64'(acc_q + 43'(prod_q)) << 20;
        r_q   <= '0;
        idx_q <= 5'd31;
      end
      ST_SQRT: begin
        if (v_q >= sq_try) begin
          v_q <= v_q - sq_try;
          r_q <= (r_q >> 1) + sq_bit;
        end else begin
          r_q <= r_q >> 1;
        end
        idx_q <= idx_q - 5'd1;
      end
      ST_DINIT: begin
        rx_q   <= {3'd0, mx, 9'd0};
        ry_q   <= {3'd0, my, 9'd0};
        satx_q <= {3'd0, mx, 9'd0} >= {1'b0, qroot};
        saty_q <= {3'd0, my, 9'd0} >= {1'b0, qroot};
        qx_q   <= '0;
        qy_q   <= '0;
        idx_q  <= 5'd16;
      end
      ST_DIV: begin
        if (rx_sh >= {1'b0, qroot}) begin
          rx_q <= rx_sh - {1'b0, qroot};
          qx_q <= {qx_q[15:0], 1'b1};
        end else begin
          rx_q <= rx_sh;
          qx_q <= {qx_q[15:0], 1'b0};
        end
        if (ry_sh >= {1'b0, qroot}) begin
          ry_q <= ry_sh - {1'b0, qroot};
          qy_q <= {qy_q[15:0], 1'b1};
        end else begin
          ry_q <= ry_sh;
          qy_q <= {qy_q[15:0], 1'b0};
        end
        idx_q <= idx_q - 5'd1;
        if (idx_q == '0) begin
          dx_q <= norm_out(gx_q[20], gx_q == '0, satx_q,
                           rx_sh >= {1'b0, qroot} ? {qx_q[15:0], 1'b1} : {qx_q[15:0], 1'b0});
          dy_q <= norm_out(gy_q[20], gy_q == '0, saty_q,
                           ry_sh >= {1'b0, qroot} ? {qy_q[15:0], 1'b1} : {qy_q[15:0], 1'b0});
        end
      end
      ST_UPD: begin
        if (out_free) begin
          out_q.new_estimate <= nv;
          out_q.out_pixel    <= pix;
          out_q.end_of_frame <= task_q.end_of_frame;
        end
      end
      default: ;
    endcase
  end

  // line buffer of normalized vertical gradients
  always_ff @(posedge clk_i) begin
    if (pop_o) above_q <= line_mem[col_i];
    if (st_q == ST_LAM) line_mem[col_q] <= dy_q;
  end

  assign out_chan_o.valid = out_valid_q;
  assign out_chan_o.data  = out_q;

endmodule

/* hw/rtl/tv_gradient_descent_pixel_pass_core.sv */
// ----------------------------------------------------------------------------
// tv_gradient_descent_pixel_pass_core
// One raster pass of TV-regularized gradient descent, one pixel per word.
// ----------------------------------------------------------------------------
// Usage:
//  - in_chan_i takes one pixel word per handshake (valid & ready): the
//    estimate here, right and below, the conv and data terms, final flag.
//  - out_chan_o returns one word per input word, in order: updated estimate,
//    8-bit pixel (nonzero only on the final pass) and end-of-frame flag.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write width, height, lambda, tau and
//    eps^2; write only while the core is idle. Unknown indexes are ignored.
// Timing:
//  - The back end works one pixel at a time and takes no new word until it is
//    through with the last one; its pace is set by the 32-step bit-serial
//    square root and the 17-step divider.
//  - A two-word queue lets the front keep taking words while the back runs.
// Reset: counters, the left gradient and all valid flags clear; config
//   registers return to defaults. The line buffer is not cleared; each
//   entry is written on row 0 before it is read.
// Stall: if out_chan_o is not ready the back holds the finished word in its
//   output register and waits; the queue then fills and in_chan_i drops ready.
// ----------------------------------------------------------------------------
module tv_gradient_descent_pixel_pass_core #(
  parameter int MaxWidth = tvgd_pkg::MaxWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tvgd_stream_if.sink                    in_chan_i,
  tvgd_stream_if.source                  out_chan_o,
  input  logic                           cfg_we_i,
  input  logic [tvgd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tvgd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tvgd_pkg::*;

  localparam int ColW = $clog2(MaxWidth);
  localparam int QW   = $bits(task_t) + ColW;

  // configuration registers
  logic [10:0] image_width_q;
  logic [12:0] image_height_q;
  coef_t       coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q      <= IMAGE_WIDTH_RST;
      image_height_q     <= IMAGE_HEIGHT_RST;
      coef_q.reg_weight  <= REG_WEIGHT_RST;
      coef_q.step_size   <= STEP_SIZE_RST;
      coef_q.eps_squared <= EPS_SQUARED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  image_width_q      <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT: image_height_q     <= cfg_data_i[12:0];
        CFG_REG_WEIGHT:   coef_q.reg_weight  <= cfg_data_i;
        CFG_STEP_SIZE:    coef_q.step_size   <= cfg_data_i[17:0];
        CFG_EPS_SQUARED:  coef_q.eps_squared <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: position tracking and edge classification
  task_t           f_task;
  logic [ColW-1:0] f_col;
  logic            f_push, q_full;

  tvgd_front #(.MaxWidth(MaxWidth), .ColW(ColW)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_chan_i      (in_chan_i),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .task_o         (f_task),
    .col_o          (f_col),
    .push_o         (f_push),
    .full_i         (q_full)
  );

  // decoupling queue
  logic [QW-1:0] q_out;
  logic          q_avail, q_pop;

  tvgd_queue #(.DataW(QW), .Depth(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_task, f_col}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .avail_o (q_avail)
  );

  // back: per-pixel arithmetic
  tvgd_back #(.MaxWidth(MaxWidth), .ColW(ColW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .task_i     (q_out[QW-1:ColW]),
    .col_i      (q_out[ColW-1:0]),
    .avail_i    (q_avail),
    .pop_o      (q_pop),
    .coef_i     (coef_q),
    .out_chan_o (out_chan_o)
  );

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the TV gradient pass core word by word against an in-bench predictor
// of the fixed-point update, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb;
  import tvgd_pkg::*;

  // Predicts each output word from the accepted input words and the register
  // settings; keeps its own copy of the line buffer, left gradient and counters.
  class estimate_scoreboard;
    out_word_t   expected_words[$];
    int          grad_above[1024];
    int          grad_left;
    int          col_cnt;
    int          row_cnt;
    int          lines_valid;   // entries of the line buffer written so far
    bit [10:0]   width_reg;
    bit [12:0]   height_reg;
    bit [31:0]   lambda_reg;
    bit [17:0]   tau_reg;
    bit [31:0]   eps_reg;

    function new();
      grad_left   = 0;
      col_cnt     = 0;
      row_cnt     = 0;
      lines_valid = 0;
      width_reg   = IMAGE_WIDTH_RST;
      height_reg  = IMAGE_HEIGHT_RST;
      lambda_reg  = REG_WEIGHT_RST;
      tau_reg     = STEP_SIZE_RST;
      eps_reg     = EPS_SQUARED_RST;
      foreach (grad_above[i]) grad_above[i] = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = val[10:0];
        CFG_IMAGE_HEIGHT: height_reg = val[12:0];
        CFG_REG_WEIGHT:   lambda_reg = val;
        CFG_STEP_SIZE:    tau_reg    = val[17:0];
        CFG_EPS_SQUARED:  eps_reg    = val;
        default: ;
      endcase
    endfunction

    static function int eff_width(bit [10:0] w);
      if (w < 2) return 2;
      if (w > MaxWidthDef) return MaxWidthDef;
      return int'(w);
    endfunction

    static function bit [63:0] isqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // |g| * 2^26 / q, signed, saturated to Q1.16 in 18 bits
    static function int norm_grad(longint g, bit [63:0] q);
      bit [63:0] m, d;
      if (q == 0 || g == 0) return 0;
      m = (g < 0) ? 64'(-g) : 64'(g);
      d = (m << 26) / q;
      if (g < 0) return (d > 64'd131072) ? -131072 : -int'(d);
      return (d > 64'd131071) ? 131071 : int'(d);
    endfunction

    // divide by 2^sh, rounding half away from zero
    static function longint round_shift(longint v, int sh);
      bit [63:0] m;
      m = (v < 0) ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function void note_pixel(in_word_t w);
      out_word_t  res;
      int         wd, ht, col, dx, dy;
      bit         lc, lr;
      longint     here, gx, gy, dv, err, stp, nv;
      bit [63:0]  s, q, pix;
      wd = eff_width(width_reg);
      ht = (height_reg < 2) ? 2 : (height_reg > HeightLimit ? HeightLimit : int'(height_reg));
      lc = col_cnt >= wd - 1;
      lr = row_cnt >= ht - 1;
      col = col_cnt % MaxWidthDef;
      here = longint'(w.est_here);
      gx = lc ? 0 : longint'(w.est_right) - here;
      gy = lr ? 0 : longint'(w.est_below) - here;
      s = 64'(eps_reg) + 64'(gx * gx) + 64'(gy * gy);
      q = isqrt(s << 20);
      dx = norm_grad(gx, q);
      dy = norm_grad(gy, q);
      dv = 0;
      if (row_cnt > 0 && col_cnt > 0)
        dv = -((longint'(dy) - grad_above[col]) + (longint'(dx) - grad_left));
      err = longint'(w.conv_term) - longint'(w.data_term)
          + round_shift(longint'(lambda_reg) * dv, 32);
      stp = round_shift(longint'(tau_reg) * err, 16);
      nv = here - stp;
      if (nv > 524287) nv = 524287;
      if (nv < -524288) nv = -524288;
      pix = 0;
      if (w.final_pass && nv > 0) begin
        pix = (64'(nv) * 255 + 32768) >> 16;
        if (pix > 255) pix = 255;
      end
      grad_above[col] = dy;
      grad_left = dx;
      if (col + 1 > lines_valid) lines_valid = col + 1;
      res.new_estimate = nv[19:0];
      res.out_pixel    = pix[7:0];
      res.end_of_frame = lc && lr;
      expected_words.push_back(res);
      if (lc) begin
        col_cnt = 0;
        row_cnt = lr ? 0 : row_cnt + 1;
      end else begin
        col_cnt++;
      end
    endfunction

    // returns 1 on a match; otherwise why says what differed
    function bit check_word(out_word_t got, output string why);
      out_word_t ex;
      why = "";
      if (expected_words.size() == 0) begin
        why = $sformatf("unexpected word est=%0d pix=%0d eof=%0b",
                        got.new_estimate, got.out_pixel, got.end_of_frame);
        return 0;
      end
      ex = expected_words.pop_front();
      if (got.new_estimate !== ex.new_estimate)
        why = {why, $sformatf(" new_estimate got %0d exp %0d",
                              got.new_estimate, ex.new_estimate)};
      if (got.out_pixel !== ex.out_pixel)
        why = {why, $sformatf(" out_pixel got %0d exp %0d", got.out_pixel, ex.out_pixel)};
      if (got.end_of_frame !== ex.end_of_frame)
        why = {why, $sformatf(" end_of_frame got %0b exp %0b",
                              got.end_of_frame, ex.end_of_frame)};
      return why == "";
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tvgd_stream_if #(.word_t(in_word_t))  in_chan ();
  tvgd_stream_if #(.word_t(out_word_t)) out_chan ();

  estimate_scoreboard sb;
  int  n_errors = 0;
  bit  quiet    = 1'b0;   // no idling on either side while set

  always #4 clk_i = ~clk_i;

  tv_gradient_descent_pixel_pass_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  task automatic report(string msg);
    $display("%0t ERROR:%s", $time, msg);
    n_errors++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // sample both channels at the edge; inputs change only in the NBA region
  always @(posedge clk_i) begin : monitor
    string why;
    if (rst_ni) begin
      if (in_chan.valid && in_chan.ready) sb.note_pixel(in_chan.data);
      if (out_chan.valid && out_chan.ready)
        if (!sb.check_word(out_chan.data, why)) report(why);
    end
  end

  // output side: random stall stretches unless quiet
  initial begin : sink
    int hold;
    hold = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) hold = gap_len();
      end
    end
  end

  // one word; valid stays high across back-to-back words
  task automatic send_pixel(in_word_t w);
    int g;
    g = (!quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (g > 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= w;
    do @(posedge clk_i); while (!in_chan.ready);
  endtask

  // drop valid at the accepting edge so the last word is not taken twice
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(bit [31:0] w, bit [31:0] h, bit [31:0] lam, bit [31:0] tau,
                           bit [31:0] eps);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_REG_WEIGHT, lam);
    write_reg(CFG_STEP_SIZE, tau);
    write_reg(CFG_EPS_SQUARED, eps);
  endtask

  function automatic logic signed [19:0] near(logic signed [19:0] base);
    return base + 20'($signed($urandom_range(0, 4096)) - 2048);
  endfunction

  // smooth image-like words most of the time, full-range noise otherwise
  function automatic in_word_t rand_pixel();
    in_word_t w;
    if ($urandom_range(0, 3) != 0) begin
      w.est_here  = 20'($urandom_range(0, 70000));
      w.est_right = ($urandom_range(0, 5) == 0) ? w.est_here : near(w.est_here);
      w.est_below = ($urandom_range(0, 5) == 0) ? w.est_here : near(w.est_here);
      w.conv_term = near(w.est_here);
      w.data_term = near(w.est_here);
    end else begin
      w.est_here  = 20'($urandom());
      w.est_right = 20'($urandom());
      w.est_below = 20'($urandom());
      w.conv_term = 20'($urandom());
      w.data_term = 20'($urandom());
    end
    w.final_pass = 1'($urandom());
    return w;
  endfunction

  function automatic in_word_t mk(int h, int r, int b, int c, int d, bit f);
    in_word_t w;
    w.est_here   = 20'(h);
    w.est_right  = 20'(r);
    w.est_below  = 20'(b);
    w.conv_term  = 20'(c);
    w.data_term  = 20'(d);
    w.final_pass = f;
    return w;
  endfunction

  initial begin : stimulus
    bit [31:0] wv, hv, lam, tau, eps;
    int        ew;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a few words on the reset settings
    quiet = 1'b1;
    repeat (4) send_pixel(rand_pixel());
    drain();

    // directed: 4x3 frame, extreme coefficients, eps zero for the flat case
    write_all(4, 3, 32'hFFFF_FFFF, 32'h3FFFF, 0);
    send_pixel(mk(524287, 524287, 524287, 524287, -524288, 1));   // flat, sqrt is zero
    send_pixel(mk(524287, -524288, -524288, -524288, 524287, 1)); // largest steps
    send_pixel(mk(-524288, 524287, 524287, 0, 0, 1));
    send_pixel(mk(0, 0, 0, 0, 0, 0));                              // last column
    send_pixel(mk(131072, 0, 0, 0, 0, 1));                         // pixel clamps to 255
    send_pixel(mk(-65536, 0, 65536, 0, 0, 1));                     // negative: pixel 0
    send_pixel(mk(65536, 65535, 65537, 1, -1, 1));
    send_pixel(mk(32768, 1, -1, 100, 100, 1));
    send_pixel(mk(1, 2, 3, 4, 5, 1));                              // last row
    send_pixel(mk(-1, -2, -3, -4, -5, 0));
    send_pixel(mk(200000, -200000, 0, 0, 300000, 1));
    send_pixel(mk(65536, 0, 0, 0, 0, 1));                          // end of frame
    drain();
    write_all(3, 2, 0, 65536, 32'hFFFF_FFFF);
    repeat (6) send_pixel(rand_pixel());
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      quiet = ($urandom_range(0, 4) == 0);
      case (ph)
        0: begin wv = 1;    hv = 0;    lam = 32'hFFFF_FFFF; tau = 32'h3FFFF; eps = 32'hFFFF_FFFF; end
        1: begin wv = 2047; hv = 8191; lam = 0; tau = 0; eps = 0; end
        default: begin
          case ($urandom_range(0, 9))
            0: wv = $urandom_range(0, 1);
            1: wv = $urandom_range(0, 1) ? 1024 : 2047;
            2: wv = $urandom();
            default: wv = $urandom_range(2, 10);
          endcase
          case ($urandom_range(0, 7))
            0: hv = $urandom_range(0, 1);
            1: hv = $urandom();
            default: hv = $urandom_range(2, 6);
          endcase
          case ($urandom_range(0, 4))
            0: lam = 0;
            1: lam = 32'hFFFF_FFFF;
            2: lam = $urandom();
            default: lam = $urandom_range(0, 400000);
          endcase
          case ($urandom_range(0, 4))
            0: tau = 0;
            1: tau = 32'h3FFFF;
            default: tau = $urandom_range(0, 262143);
          endcase
          case ($urandom_range(0, 4))
            0: eps = 0;
            1: eps = $urandom();
            default: eps = $urandom_range(0, 200000);
          endcase
        end
      endcase
      // growing the width mid-frame would read line entries never written
      ew = sb.eff_width(wv[10:0]);
      if (sb.row_cnt > 0 && ew > sb.lines_valid) wv = sb.lines_valid;
      write_all(wv, hv, lam, tau, eps);
      if ($urandom_range(0, 2) == 0)
        write_reg(CfgIdxW'(CFG_IMAGE_WIDTH + 5), $urandom()); // ignored
      repeat (73) send_pixel(rand_pixel());
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #8ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
